// ----- rtl/core/cherenkov_emission_point_finder_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the emission point finder.
// ----------------------------------------------------------------------------
`ifndef CHERENKOV_EMISSION_POINT_FINDER_MACROS_SVH
`define CHERENKOV_EMISSION_POINT_FINDER_MACROS_SVH

`ifndef SYNTHESIS
`define CEPF_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define CEPF_ASSERT_NEVER(name, clk, rst_n, expr, msg) \
  `CEPF_ASSERT(name, clk, rst_n, !(expr), msg)
`else
`define CEPF_ASSERT(name, clk, rst_n, prop, msg)
`define CEPF_ASSERT_NEVER(name, clk, rst_n, expr, msg)
`endif

`endif

// ----- rtl/core/cepf_pkg.sv -----
// ----------------------------------------------------------------------------
// cepf_pkg
// Widths, types and constants of the emission point finder.
// ----------------------------------------------------------------------------
package cepf_pkg;

  localparam int POS_W        = 24;
  localparam int DIR_W        = 18;
  localparam int COS_W        = 17;
  localparam int REL_W        = 25;
  localparam int CNT_W        = 12;
  localparam int D2_W         = 36;
  localparam int DOT_W        = 45;
  localparam int PRD_W        = 43;
  localparam int MAG_W        = 44;
  localparam int Q_W          = 86;
  localparam int ACC_W        = 120;
  localparam int ROOT_W       = 60;
  localparam int UMUL_W       = 29;
  localparam int SH_W         = 7;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 24;
  localparam int QUEUE_DEPTH  = 2;
  localparam int MAX_HITS_DEF = 2048;

  localparam logic [POS_W-1:0] DIST_MAX   = 24'h7FFFFF;
  localparam logic [POS_W-1:0] DIST_MIN   = 24'h800000;
  localparam logic [DIR_W-1:0] DIR_Z_RST  = 18'h10000;
  localparam logic [COS_W-1:0] COS_SQ_RST = 17'd36193;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_VERTEX_X,
    CFG_VERTEX_Y,
    CFG_VERTEX_Z,
    CFG_DIR_X,
    CFG_DIR_Y,
    CFG_DIR_Z,
    CFG_COS_SQ
  } cfg_idx_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PROD,
    S_CLASS,
    S_SQ,
    S_SCALE,
    S_DIV1,
    S_SQRT,
    S_DIV2,
    S_EMIT
  } back_state_e;

  typedef struct packed {
    logic signed [REL_W-1:0] rel_x;
    logic signed [REL_W-1:0] rel_y;
    logic signed [REL_W-1:0] rel_z;
    logic                    sensor_kind;
    logic                    last_hit;
  } hit_t;

  typedef struct packed {
    logic signed [DIR_W-1:0] dir_x;
    logic signed [DIR_W-1:0] dir_y;
    logic signed [DIR_W-1:0] dir_z;
    logic [COS_W-1:0]        cos_sq;
  } track_t;

  typedef struct packed {
    logic             start;
    logic [ACC_W-1:0] dividend;
    logic [D2_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [ACC_W-1:0] quot;
  } div_rsp_t;

  typedef struct packed {
    logic             start;
    logic [ACC_W-1:0] radicand;
  } sqrt_req_t;

  typedef struct packed {
    logic              done;
    logic [ROOT_W-1:0] root;
  } sqrt_rsp_t;

endpackage

// ----- rtl/core/cepf_intf.sv -----
// ----------------------------------------------------------------------------
// cepf_hit_if / cepf_res_if
// Valid/ready channels for hits in and per-hit results out.
// ----------------------------------------------------------------------------
interface cepf_hit_if;
  logic        valid;
  logic        ready;
  logic [23:0] hit_x;
  logic [23:0] hit_y;
  logic [23:0] hit_z;
  logic        sensor_kind;
  logic        last_hit;

  modport source (output valid, hit_x, hit_y, hit_z, sensor_kind, last_hit, input ready);
  modport sink   (input valid, hit_x, hit_y, hit_z, sensor_kind, last_hit, output ready);
endinterface

interface cepf_res_if;
  logic        valid;
  logic        ready;
  logic [23:0] track_distance;
  logic        distance_valid;
  logic [23:0] running_max;
  logic [23:0] running_min;
  logic [11:0] tube_count;
  logic [11:0] picosecond_count;
  logic        event_done;

  modport source (output valid, track_distance, distance_valid, running_max, running_min,
                  tube_count, picosecond_count, event_done, input ready);
  modport sink   (input valid, track_distance, distance_valid, running_max, running_min,
                  tube_count, picosecond_count, event_done, output ready);
endinterface

// ----- rtl/core/cherenkov_emission_point_finder.sv -----
// Path: the front registers each hit transfer and the queue holds it for the back
// end; alpha-zero, tie and negative-discriminant hits need only the products and
// a class check, the general case also two divisions and a square root. The back
// end takes one hit at a time, the next only once the last result is emitted.
// Reset: asynchronous, active low; registers take their documented defaults and
// the running extremes and counts clear, as they do after each last hit.
// ----------------------------------------------------------------------------
// cherenkov_emission_point_finder
// Per-hit emission distance along the track, with per-event extremes and counts.
// ----------------------------------------------------------------------------
module cherenkov_emission_point_finder #(
  parameter int MAX_HITS = cepf_pkg::MAX_HITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [cepf_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [cepf_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  cepf_hit_if.sink                           hit_i,
  cepf_res_if.source                         res_o
);
  import cepf_pkg::*;

  logic signed [POS_W-1:0] vertex_x_q, vertex_y_q, vertex_z_q;
  track_t                  track_q;

  logic      push_vld, push_rdy, pop_vld, pop;
  hit_t      push_item, pop_item;
  div_req_t  div_req;
  div_rsp_t  div_rsp;
  sqrt_req_t sqrt_req;
  sqrt_rsp_t sqrt_rsp;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vertex_x_q     <= '0;
      vertex_y_q     <= '0;
      vertex_z_q     <= '0;
      track_q.dir_x  <= '0;
      track_q.dir_y  <= '0;
      track_q.dir_z  <= DIR_Z_RST;
      track_q.cos_sq <= COS_SQ_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_VERTEX_X: vertex_x_q     <= cfg_data_i;
        CFG_VERTEX_Y: vertex_y_q     <= cfg_data_i;
        CFG_VERTEX_Z: vertex_z_q     <= cfg_data_i;
        CFG_DIR_X:    track_q.dir_x  <= cfg_data_i[DIR_W-1:0];
        CFG_DIR_Y:    track_q.dir_y  <= cfg_data_i[DIR_W-1:0];
        CFG_DIR_Z:    track_q.dir_z  <= cfg_data_i[DIR_W-1:0];
        CFG_COS_SQ:   track_q.cos_sq <= cfg_data_i[COS_W-1:0];
        default: ;
      endcase
    end
  end

  cepf_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .hit         (hit_i),
    .vertex_x_i  (vertex_x_q),
    .vertex_y_i  (vertex_y_q),
    .vertex_z_i  (vertex_z_q),
    .push_vld_o  (push_vld),
    .push_item_o (push_item),
    .push_rdy_i  (push_rdy)
  );

  cepf_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_vld_i  (push_vld),
    .push_item_i (push_item),
    .push_rdy_o  (push_rdy),
    .pop_vld_o   (pop_vld),
    .pop_item_o  (pop_item),
    .pop_i       (pop)
  );

  cepf_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  cepf_sqrt u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (sqrt_req),
    .rsp_o  (sqrt_rsp)
  );

  cepf_back #(
    .MAX_HITS (MAX_HITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .track_i    (track_q),
    .item_vld_i (pop_vld),
    .item_i     (pop_item),
    .pop_o      (pop),
    .div_req_o  (div_req),
    .div_rsp_i  (div_rsp),
    .sqrt_req_o (sqrt_req),
    .sqrt_rsp_i (sqrt_rsp),
    .res        (res_o)
  );

endmodule

// ----- rtl/core/cepf_front.sv -----
// ----------------------------------------------------------------------------
// cepf_front
// Takes hit transfers and forms the ray from the vertex to the sensor.
// ----------------------------------------------------------------------------
module cepf_front (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  cepf_hit_if.sink                            hit,
  input  logic signed [cepf_pkg::POS_W-1:0]   vertex_x_i,
  input  logic signed [cepf_pkg::POS_W-1:0]   vertex_y_i,
  input  logic signed [cepf_pkg::POS_W-1:0]   vertex_z_i,
  output logic                                push_vld_o,
  output cepf_pkg::hit_t                      push_item_o,
  input  logic                                push_rdy_i
);
  import cepf_pkg::*;

  logic vld_q;
  hit_t ent_q;
  hit_t ent_d;

  assign hit.ready = !vld_q || push_rdy_i;

  always_comb begin
    ent_d.rel_x       = REL_W'($signed(hit.hit_x)) - REL_W'(vertex_x_i);
    ent_d.rel_y       = REL_W'($signed(hit.hit_y)) - REL_W'(vertex_y_i);
    ent_d.rel_z       = REL_W'($signed(hit.hit_z)) - REL_W'(vertex_z_i);
    ent_d.sensor_kind = hit.sensor_kind;
    ent_d.last_hit    = hit.last_hit;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (hit.valid && hit.ready) begin
      vld_q <= 1'b1;
    end else if (push_rdy_i) begin
      vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (hit.valid && hit.ready) begin
      ent_q <= ent_d;
    end
  end

  assign push_vld_o  = vld_q;
  assign push_item_o = ent_q;

endmodule

// ----- rtl/core/cepf_fifo.sv -----
// ----------------------------------------------------------------------------
// cepf_fifo
// Short queue between the front and the back.
// ----------------------------------------------------------------------------
module cepf_fifo #(
  parameter int DEPTH = cepf_pkg::QUEUE_DEPTH
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_vld_i,
  input  cepf_pkg::hit_t push_item_i,
  output logic           push_rdy_o,
  output logic           pop_vld_o,
  output cepf_pkg::hit_t pop_item_o,
  input  logic           pop_i
);
  import cepf_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  hit_t             mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q;
  logic [PTR_W-1:0] rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;
  logic             push;
  logic             pop;

  assign push_rdy_o = (cnt_q != CNT_W'(DEPTH));
  assign pop_vld_o  = (cnt_q != '0);
  assign push       = push_vld_i && push_rdy_o;
  assign pop        = pop_i && pop_vld_o;
  assign pop_item_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

// ----- rtl/core/cepf_div.sv -----
// ----------------------------------------------------------------------------
// cepf_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module cepf_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cepf_pkg::div_req_t req_i,
  output cepf_pkg::div_rsp_t rsp_o
);
  import cepf_pkg::*;

  localparam int IT_W = $clog2(ACC_W);

  logic [ACC_W-1:0] n_q;
  logic [D2_W-1:0]  rem_q;
  logic [D2_W-1:0]  den_q;
  logic [IT_W-1:0]  it_q;
  logic             busy_q;
  logic             done_q;
  logic [D2_W:0]    rem_sh;
  logic [D2_W:0]    rem_sub;
  logic             ge;

  assign rem_sh  = {rem_q, n_q[ACC_W-1]};
  assign rem_sub = rem_sh - {1'b0, den_q};
  assign ge      = (rem_sh >= {1'b0, den_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      it_q   <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        it_q   <= '0;
      end else if (busy_q) begin
        it_q <= it_q + 1'b1;
        if (it_q == IT_W'(ACC_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      n_q   <= req_i.dividend;
      den_q <= req_i.divisor;
      rem_q <= '0;
    end else if (busy_q) begin
      rem_q <= ge ? rem_sub[D2_W-1:0] : rem_sh[D2_W-1:0];
      n_q   <= {n_q[ACC_W-2:0], ge};
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = n_q;

endmodule

// ----- rtl/core/cepf_sqrt.sv -----
// ----------------------------------------------------------------------------
// cepf_sqrt
// Digit-by-digit integer square root, one root bit per cycle.
// ----------------------------------------------------------------------------
module cepf_sqrt (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cepf_pkg::sqrt_req_t req_i,
  output cepf_pkg::sqrt_rsp_t rsp_o
);
  import cepf_pkg::*;

  localparam int IT_W  = $clog2(ROOT_W);
  localparam int REM_W = ROOT_W + 2;

  logic [ACC_W-1:0]  n_q;
  logic [REM_W-1:0]  rem_q;
  logic [ROOT_W-1:0] root_q;
  logic [IT_W-1:0]   it_q;
  logic              busy_q;
  logic              done_q;
  logic [REM_W+1:0]  rem_sh;
  logic [REM_W+1:0]  trial;
  logic [REM_W+1:0]  rem_sub;
  logic              ge;

  assign rem_sh  = {rem_q, n_q[ACC_W-1:ACC_W-2]};
  assign trial   = (REM_W + 2)'({root_q, 2'b01});
  assign rem_sub = rem_sh - trial;
  assign ge      = (rem_sh >= trial);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      it_q   <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        it_q   <= '0;
      end else if (busy_q) begin
        it_q <= it_q + 1'b1;
        if (it_q == IT_W'(ROOT_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      n_q    <= req_i.radicand;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rem_q  <= ge ? rem_sub[REM_W-1:0] : rem_sh[REM_W-1:0];
      root_q <= {root_q[ROOT_W-2:0], ge};
      n_q    <= {n_q[ACC_W-3:0], 2'b00};
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.root = root_q;

endmodule

// ----- rtl/core/cepf_back.sv -----
// ----------------------------------------------------------------------------
// cepf_back
// Sequencer that solves for the emission distance and keeps event state.
// ----------------------------------------------------------------------------
`include "cherenkov_emission_point_finder_macros.svh"

module cepf_back #(
  parameter int MAX_HITS = cepf_pkg::MAX_HITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cepf_pkg::track_t    track_i,
  input  logic                item_vld_i,
  input  cepf_pkg::hit_t      item_i,
  output logic                pop_o,
  output cepf_pkg::div_req_t  div_req_o,
  input  cepf_pkg::div_rsp_t  div_rsp_i,
  output cepf_pkg::sqrt_req_t sqrt_req_o,
  input  cepf_pkg::sqrt_rsp_t sqrt_rsp_i,
  cepf_res_if.source          res
);
  import cepf_pkg::*;

  localparam int CNT_MAX = (1 << CNT_W) - 1;
  localparam logic [CNT_W-1:0] CAP = CNT_W'((MAX_HITS > CNT_MAX) ? CNT_MAX : MAX_HITS);

  back_state_e state_q, state_d;
  logic [3:0]  step_q, step_d;

  hit_t                    item_q;
  logic [D2_W-1:0]         d2_q;
  logic signed [DOT_W-1:0] p_q, cx_q, cy_q, cz_q;
  logic signed [PRD_W-1:0] prod_q;
  logic [2*UMUL_W-1:0]     uprod_q;
  logic [SH_W-1:0]         ush_q;
  logic [ACC_W-1:0]        acc_q;
  logic [Q_W-1:0]          q_q;
  logic [D2_W-1:0]         kdiv_q;
  logic                    neg_q;
  logic [POS_W-1:0]        dist_q;
  logic                    valid_q;

  logic [POS_W-1:0] max_q, min_q;
  logic [CNT_W-1:0] tube_q, ps_q;

  logic             out_vld_q;
  logic [POS_W-1:0] out_dist_q, out_max_q, out_min_q;
  logic [CNT_W-1:0] out_tube_q, out_ps_q;
  logic             out_dv_q, out_last_q;

  logic signed [DIR_W-1:0] ma;
  logic signed [REL_W-1:0] mb;
  logic signed [PRD_W-1:0] mprod;
  logic [UMUL_W-1:0]       ua, ub;
  logic [SH_W-1:0]         ush;
  logic [2*UMUL_W-1:0]     umul;
  logic [ACC_W-1:0]        acc_nxt;
  logic [MAG_W-1:0]        mag_x, mag_y, mag_z, mag_sel;
  logic signed [DOT_W-1:0] ncx, ncy, ncz;
  logic signed [37:0]      kk;
  logic                    crs_zero;
  logic signed [ROOT_W+1:0] num, num_n;
  logic [ROOT_W:0]         num_mag;
  logic [ACC_W-1:0]        qt;
  logic [POS_W-1:0]        dist_fin;
  logic                    out_free, emit;
  logic [POS_W-1:0]        max_n, min_n;
  logic [CNT_W-1:0]        tube_n, ps_n;

  // ray products, one per cycle
  always_comb begin
    ma = track_i.dir_x;
    mb = item_q.rel_x;
    case (step_q)
      4'd0:    begin ma = track_i.dir_x; mb = REL_W'(track_i.dir_x); end
      4'd1:    begin ma = track_i.dir_y; mb = REL_W'(track_i.dir_y); end
      4'd2:    begin ma = track_i.dir_z; mb = REL_W'(track_i.dir_z); end
      4'd3:    begin ma = track_i.dir_x; mb = item_q.rel_x; end
      4'd4:    begin ma = track_i.dir_y; mb = item_q.rel_y; end
      4'd5:    begin ma = track_i.dir_z; mb = item_q.rel_z; end
      4'd6:    begin ma = track_i.dir_y; mb = item_q.rel_z; end
      4'd7:    begin ma = track_i.dir_z; mb = item_q.rel_y; end
      4'd8:    begin ma = track_i.dir_z; mb = item_q.rel_x; end
      4'd9:    begin ma = track_i.dir_x; mb = item_q.rel_z; end
      4'd10:   begin ma = track_i.dir_x; mb = item_q.rel_y; end
      4'd11:   begin ma = track_i.dir_y; mb = item_q.rel_x; end
      default: begin ma = track_i.dir_x; mb = item_q.rel_x; end
    endcase
  end
  assign mprod = ma * mb;

  assign ncx   = -cx_q;
  assign ncy   = -cy_q;
  assign ncz   = -cz_q;
  assign mag_x = cx_q[DOT_W-1] ? ncx[MAG_W-1:0] : cx_q[MAG_W-1:0];
  assign mag_y = cy_q[DOT_W-1] ? ncy[MAG_W-1:0] : cy_q[MAG_W-1:0];
  assign mag_z = cz_q[DOT_W-1] ? ncz[MAG_W-1:0] : cz_q[MAG_W-1:0];

  // |d x v|^2 from 22-bit halves, then scaled by cos^2 in 29-bit slices
  always_comb begin
    ua      = '0;
    ub      = '0;
    ush     = '0;
    mag_sel = mag_x;
    if (state_q == S_SQ) begin
      if (step_q < 4'd3) begin
        mag_sel = mag_x;
      end else if (step_q < 4'd6) begin
        mag_sel = mag_y;
      end else begin
        mag_sel = mag_z;
      end
      case (step_q)
        4'd0, 4'd3, 4'd6: begin
          ua = UMUL_W'(mag_sel[MAG_W-1:22]); ub = UMUL_W'(mag_sel[MAG_W-1:22]);
          ush = SH_W'(44);
        end
        4'd1, 4'd4, 4'd7: begin
          ua = UMUL_W'(mag_sel[MAG_W-1:22]); ub = UMUL_W'(mag_sel[21:0]);
          ush = SH_W'(23);
        end
        4'd2, 4'd5, 4'd8: begin
          ua = UMUL_W'(mag_sel[21:0]); ub = UMUL_W'(mag_sel[21:0]);
          ush = '0;
        end
        default: ;
      endcase
    end else begin
      ua = UMUL_W'(track_i.cos_sq);
      case (step_q)
        4'd0:    begin ub = q_q[28:0];                ush = SH_W'(16); end
        4'd1:    begin ub = q_q[57:29];               ush = SH_W'(45); end
        4'd2:    begin ub = UMUL_W'(q_q[Q_W-1:58]);   ush = SH_W'(74); end
        default: ;
      endcase
    end
  end
  assign umul    = ua * ub;
  assign acc_nxt = acc_q + (ACC_W'(uprod_q) << ush_q);

  assign kk       = $signed(38'(d2_q)) - $signed(38'({track_i.cos_sq, 16'h0000}));
  assign crs_zero = (cx_q == '0) && (cy_q == '0) && (cz_q == '0);

  assign num     = (ROOT_W + 2)'(p_q) - $signed({2'b00, sqrt_rsp_i.root});
  assign num_n   = -num;
  assign num_mag = num[ROOT_W+1] ? num_n[ROOT_W:0] : num[ROOT_W:0];

  assign qt = div_rsp_i.quot;
  always_comb begin
    if (neg_q) begin
      if ((|qt[ACC_W-1:24]) || (qt[23] && (|qt[22:0]))) begin
        dist_fin = DIST_MIN;
      end else begin
        dist_fin = -qt[POS_W-1:0];
      end
    end else if (|qt[ACC_W-1:23]) begin
      dist_fin = DIST_MAX;
    end else begin
      dist_fin = qt[POS_W-1:0];
    end
  end

  assign div_req_o.start    = ((state_q == S_SCALE) && (step_q == 4'd3)) ||
                              ((state_q == S_SQRT) && sqrt_rsp_i.done);
  assign div_req_o.dividend = (state_q == S_SCALE) ? acc_nxt : ACC_W'({num_mag, 16'h0000});
  assign div_req_o.divisor  = (state_q == S_SCALE) ? kdiv_q : d2_q;
  assign sqrt_req_o.start    = (state_q == S_DIV1) && div_rsp_i.done;
  assign sqrt_req_o.radicand = qt;

  assign pop_o    = (state_q == S_IDLE) && item_vld_i;
  assign out_free = !out_vld_q || res.ready;
  assign emit     = (state_q == S_EMIT) && out_free;

  always_comb begin
    max_n = max_q;
    min_n = min_q;
    if (valid_q && ($signed(dist_q) > $signed(max_q))) max_n = dist_q;
    if (valid_q && ($signed(dist_q) < $signed(min_q))) min_n = dist_q;
    tube_n = tube_q;
    ps_n   = ps_q;
    if (!item_q.sensor_kind) begin
      if (tube_q < CAP) tube_n = tube_q + 1'b1;
    end else begin
      if (ps_q < CAP) ps_n = ps_q + 1'b1;
    end
  end

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    case (state_q)
      S_IDLE: begin
        if (item_vld_i) begin
          state_d = S_PROD;
          step_d  = '0;
        end
      end
      S_PROD: begin
        if (step_q == 4'd12) begin
          state_d = S_CLASS;
          step_d  = '0;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      S_CLASS: begin
        if ((d2_q == '0) || (kk == '0) || kk[37] || (track_i.cos_sq == '0) || crs_zero) begin
          state_d = S_EMIT;
        end else begin
          state_d = S_SQ;
        end
      end
      S_SQ: begin
        if (step_q == 4'd9) begin
          state_d = S_SCALE;
          step_d  = '0;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      S_SCALE: begin
        if (step_q == 4'd3) begin
          state_d = S_DIV1;
          step_d  = '0;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      S_DIV1:  if (div_rsp_i.done) state_d = S_SQRT;
      S_SQRT:  if (sqrt_rsp_i.done) state_d = S_DIV2;
      S_DIV2:  if (div_rsp_i.done) state_d = S_EMIT;
      S_EMIT:  if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      step_q    <= '0;
      out_vld_q <= 1'b0;
      max_q     <= DIST_MIN;
      min_q     <= DIST_MAX;
      tube_q    <= '0;
      ps_q      <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      if (emit) begin
        out_vld_q <= 1'b1;
        if (item_q.last_hit) begin
          max_q  <= DIST_MIN;
          min_q  <= DIST_MAX;
          tube_q <= '0;
          ps_q   <= '0;
        end else begin
          max_q  <= max_n;
          min_q  <= min_n;
          tube_q <= tube_n;
          ps_q   <= ps_n;
        end
      end else if (res.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (item_vld_i) begin
          item_q <= item_i;
          d2_q   <= '0;
          p_q    <= '0;
          cx_q   <= '0;
          cy_q   <= '0;
          cz_q   <= '0;
        end
      end
      S_PROD: begin
        if (step_q != 4'd12) prod_q <= mprod;
        case (step_q)
          4'd1, 4'd2, 4'd3: d2_q <= d2_q + prod_q[D2_W-1:0];
          4'd4, 4'd5, 4'd6: p_q  <= p_q + DOT_W'(prod_q);
          4'd7:             cx_q <= cx_q + DOT_W'(prod_q);
          4'd8:             cx_q <= cx_q - DOT_W'(prod_q);
          4'd9:             cy_q <= cy_q + DOT_W'(prod_q);
          4'd10:            cy_q <= cy_q - DOT_W'(prod_q);
          4'd11:            cz_q <= cz_q + DOT_W'(prod_q);
          4'd12:            cz_q <= cz_q - DOT_W'(prod_q);
          default: ;
        endcase
      end
      S_CLASS: begin
        dist_q  <= '0;
        valid_q <= !((d2_q == '0) || (kk == '0) || (kk[37] && !crs_zero));
        kdiv_q  <= kk[D2_W-1:0];
        acc_q   <= '0;
      end
      S_SQ: begin
        if (step_q != 4'd9) begin
          uprod_q <= umul;
          ush_q   <= ush;
        end
        if (step_q == 4'd9) begin
          q_q   <= acc_nxt[Q_W-1:0];
          acc_q <= '0;
        end else if (step_q != 4'd0) begin
          acc_q <= acc_nxt;
        end
      end
      S_SCALE: begin
        if (step_q != 4'd3) begin
          uprod_q <= umul;
          ush_q   <= ush;
        end
        if (step_q != 4'd0) acc_q <= acc_nxt;
      end
      S_SQRT: begin
        if (sqrt_rsp_i.done) neg_q <= num[ROOT_W+1];
      end
      S_DIV2: begin
        if (div_rsp_i.done) begin
          dist_q  <= dist_fin;
          valid_q <= 1'b1;
        end
      end
      default: ;
    endcase
    if (emit) begin
      out_dist_q <= dist_q;
      out_dv_q   <= valid_q;
      out_max_q  <= max_n;
      out_min_q  <= min_n;
      out_tube_q <= tube_n;
      out_ps_q   <= ps_n;
      out_last_q <= item_q.last_hit;
    end
  end

  assign res.valid            = out_vld_q;
  assign res.track_distance   = out_dist_q;
  assign res.distance_valid   = out_dv_q;
  assign res.running_max      = out_max_q;
  assign res.running_min      = out_min_q;
  assign res.tube_count       = out_tube_q;
  assign res.picosecond_count = out_ps_q;
  assign res.event_done       = out_last_q;

  `CEPF_ASSERT_NEVER(a_cnt_cap, clk_i, rst_ni, (tube_q > CAP) || (ps_q > CAP), "count above cap")
  `CEPF_ASSERT(a_inv_zero, clk_i, rst_ni, (res.valid && !res.distance_valid) |-> (res.track_distance == '0), "invalid hit with distance")
  `CEPF_ASSERT(a_clear, clk_i, rst_ni, (emit && item_q.last_hit) |=> ((tube_q == '0) && (ps_q == '0) && (max_q == DIST_MIN)), "event state not cleared")
  `CEPF_ASSERT(a_order, clk_i, rst_ni, (res.valid && res.distance_valid) |-> ($signed(res.running_max) >= $signed(res.running_min)), "extremes out of order")

endmodule

// ----- sim/cepf_checker.sv -----
// ----------------------------------------------------------------------------
// cepf_checker
// Watches the configuration port and both channels of the emission point
// finder, predicts every per-hit result from its own copy of the track setup
// and the event state, and compares transfers field by field in order.
// ----------------------------------------------------------------------------
module cepf_checker
  import cepf_pkg::*;
#(
  parameter int MAX_HITS = MAX_HITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  cepf_hit_if                   hit,
  cepf_res_if                   res,
  output int                    fail_count_o,
  output int                    pending_o
);

  typedef logic [127:0] wide_t;

  typedef struct {
    logic [23:0] distance;
    logic        dist_ok;
    logic [23:0] dist_max;
    logic [23:0] dist_min;
    logic [11:0] tubes;
    logic [11:0] picos;
    logic        done;
  } summary_t;

  localparam longint DMAX = 8388607;
  localparam longint DMIN = -8388608;
  localparam int unsigned HIT_CAP = (MAX_HITS > 4095) ? 4095 : MAX_HITS;

  logic signed [23:0] vtx_x, vtx_y, vtx_z;
  logic signed [17:0] dir_x, dir_y, dir_z;
  logic [16:0]        cos_sq;
  longint             max_dist, min_dist;
  int unsigned        tube_hits, pico_hits;
  summary_t           summary_q[$];

  function automatic logic [63:0] magnitude(input longint v);
    return (v < 0) ? 64'(-v) : 64'(v);
  endfunction

  function automatic summary_t emission_summary(input logic [23:0] hx, hy, hz,
                                                input logic kind, last);
    longint   vx, vy, vz, dx, dy, dz, d2, proj, kk, cx, cy, cz, num;
    wide_t    q, n, qq;
    logic [63:0] root, cand, mag;
    logic     ok;
    longint   lam;
    summary_t r;
    vx = longint'($signed(hx)) - longint'(vtx_x);
    vy = longint'($signed(hy)) - longint'(vtx_y);
    vz = longint'($signed(hz)) - longint'(vtx_z);
    dx = dir_x; dy = dir_y; dz = dir_z;
    d2 = dx * dx + dy * dy + dz * dz;
    proj = dx * vx + dy * vy + dz * vz;
    kk = d2 - (longint'(cos_sq) << 16);
    cx = dy * vz - dz * vy;
    cy = dz * vx - dx * vz;
    cz = dx * vy - dy * vx;
    q = wide_t'(magnitude(cx)) * wide_t'(magnitude(cx))
      + wide_t'(magnitude(cy)) * wide_t'(magnitude(cy))
      + wide_t'(magnitude(cz)) * wide_t'(magnitude(cz));
    ok = 1'b1;
    lam = 0;
    if (d2 == 0 || kk == 0) begin
      ok = 1'b0;
    end else if (kk < 0) begin
      if (q != 0) ok = 1'b0;
    end else if (cos_sq != 0 && q != 0) begin
      n = (q * wide_t'(cos_sq)) << 16;
      n = n / wide_t'(kk);
      root = 0;
      for (int b = 63; b >= 0; b--) begin
        cand = root | (64'd1 << b);
        if (wide_t'(cand) * wide_t'(cand) <= n) root = cand;
      end
      num = proj - longint'(root);
      mag = magnitude(num);
      qq = (wide_t'(mag) << 16) / wide_t'(d2);
      if (num < 0) lam = (qq > 8388608) ? DMIN : -longint'(qq[63:0]);
      else         lam = (qq > 8388607) ? DMAX : longint'(qq[63:0]);
    end
    if (ok) begin
      if (lam > max_dist) max_dist = lam;
      if (lam < min_dist) min_dist = lam;
    end
    if (!kind) begin
      if (tube_hits < HIT_CAP) tube_hits++;
    end else begin
      if (pico_hits < HIT_CAP) pico_hits++;
    end
    r.distance = lam[23:0];
    r.dist_ok  = ok;
    r.dist_max = max_dist[23:0];
    r.dist_min = min_dist[23:0];
    r.tubes    = tube_hits[11:0];
    r.picos    = pico_hits[11:0];
    r.done     = last;
    if (last) begin
      max_dist = DMIN; min_dist = DMAX; tube_hits = 0; pico_hits = 0;
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    summary_t e;
    if (!rst_ni) begin
      vtx_x = '0; vtx_y = '0; vtx_z = '0;
      dir_x = '0; dir_y = '0; dir_z = DIR_Z_RST;
      cos_sq = COS_SQ_RST;
      max_dist = DMIN; min_dist = DMAX; tube_hits = 0; pico_hits = 0;
      summary_q.delete();
      fail_count_o = 0;
      pending_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_VERTEX_X: vtx_x = cfg_data_i[23:0];
          CFG_VERTEX_Y: vtx_y = cfg_data_i[23:0];
          CFG_VERTEX_Z: vtx_z = cfg_data_i[23:0];
          CFG_DIR_X:    dir_x = cfg_data_i[17:0];
          CFG_DIR_Y:    dir_y = cfg_data_i[17:0];
          CFG_DIR_Z:    dir_z = cfg_data_i[17:0];
          CFG_COS_SQ:   cos_sq = cfg_data_i[16:0];
          default: ;
        endcase
      end
      if (res.valid && res.ready) begin
        if (summary_q.size() == 0) begin
          $error("result transfer with no hit outstanding");
          fail_count_o++;
        end else begin
          e = summary_q.pop_front();
          if (res.track_distance !== e.distance) begin
            $error("track_distance expected %0d got %0d",
                   $signed(e.distance), $signed(res.track_distance));
            fail_count_o++;
          end
          if (res.distance_valid !== e.dist_ok) begin
            $error("distance_valid expected %0d got %0d", e.dist_ok, res.distance_valid);
            fail_count_o++;
          end
          if (res.running_max !== e.dist_max) begin
            $error("running_max expected %0d got %0d",
                   $signed(e.dist_max), $signed(res.running_max));
            fail_count_o++;
          end
          if (res.running_min !== e.dist_min) begin
            $error("running_min expected %0d got %0d",
                   $signed(e.dist_min), $signed(res.running_min));
            fail_count_o++;
          end
          if (res.tube_count !== e.tubes) begin
            $error("tube_count expected %0d got %0d", e.tubes, res.tube_count);
            fail_count_o++;
          end
          if (res.picosecond_count !== e.picos) begin
            $error("picosecond_count expected %0d got %0d", e.picos, res.picosecond_count);
            fail_count_o++;
          end
          if (res.event_done !== e.done) begin
            $error("event_done expected %0d got %0d", e.done, res.event_done);
            fail_count_o++;
          end
        end
      end
      if (hit.valid && hit.ready)
        summary_q.insert(summary_q.size(),
                         emission_summary(hit.hit_x, hit.hit_y, hit.hit_z,
                                          hit.sensor_kind, hit.last_hit));
      pending_o = summary_q.size();
    end
  end

endmodule

// ----- sim/cherenkov_emission_point_finder_tb.sv -----
// ----------------------------------------------------------------------------
// cherenkov_emission_point_finder_tb
// Drives hits and track setups into the emission point finder: directed
// corner cases (zero ray, tie, negative discriminant, alpha zero, long
// event, field extremes) then randomised events, with random gaps on
// both channels and one long result stall. The checker gives the verdict data.
// ----------------------------------------------------------------------------
module cherenkov_emission_point_finder_tb;
  import cepf_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  int                    fail_count;
  int                    pending;
  int                    cycles = 0;
  int                    results_seen = 0;

  cepf_hit_if hit_if ();
  cepf_res_if res_if ();

  cherenkov_emission_point_finder uut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .hit_i     (hit_if),
    .res_o     (res_if)
  );

  cepf_checker chk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .hit         (hit_if),
    .res         (res_if),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // result side: random stalls, calm stretches, one long hold-off
  initial begin
    int gap;
    bit held;
    held = 0;
    res_if.ready = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (!held && results_seen >= 40) begin
        gap = 800;
        held = 1;
      end else if ((results_seen / 64) % 3 == 1) begin
        gap = 0;
      end else begin
        gap = $urandom_range(0, 6);
      end
      if (gap > 0) begin
        res_if.ready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      res_if.ready <= 1'b1;
      @(posedge clk_i);
      while (!res_if.valid) @(posedge clk_i);
      results_seen++;
      @(negedge clk_i);
    end
  end

  task automatic send_hit(input logic [23:0] x, y, z, input logic kind, last,
                          input bit calm = 0);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      hit_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    hit_if.hit_x <= x;
    hit_if.hit_y <= y;
    hit_if.hit_z <= z;
    hit_if.sensor_kind <= kind;
    hit_if.last_hit <= last;
    hit_if.valid <= 1'b1;
    @(posedge clk_i);
    while (!hit_if.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic settle();
    hit_if.valid <= 1'b0;
    @(negedge clk_i);
    wait (pending == 0);
    repeat (40) @(negedge clk_i);
  endtask

  task automatic load_track(input logic [23:0] vx, vy, vz,
                            input logic [17:0] dx, dy, dz, input logic [16:0] c2);
    logic [23:0] vals[7];
    vals = '{vx, vy, vz, 24'($signed(dx)), 24'($signed(dy)), 24'($signed(dz)), 24'(c2)};
    settle();
    cfg_we_i <= 1'b1;
    for (int i = 0; i < 7; i++) begin
      cfg_idx_i <= CFG_IDX_W'(i);
      cfg_data_i <= vals[i];
      @(negedge clk_i);
    end
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  function automatic logic [23:0] rand_pos();
    logic [31:0] r;
    r = $urandom();
    if ($urandom_range(0, 3) == 0) return r[23:0];
    return {{4{r[19]}}, r[19:0]};
  endfunction

  initial begin
    logic [31:0] r;
    int burst;
    hit_if.valid = 1'b0;
    hit_if.hit_x = '0;
    hit_if.hit_y = '0;
    hit_if.hit_z = '0;
    hit_if.sensor_kind = 1'b0;
    hit_if.last_hit = 1'b0;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset setup: zero ray, on-axis tie, general case, field extremes
    send_hit(24'd0, 24'd0, 24'd0, 1'b0, 1'b0);
    send_hit(24'd0, 24'd0, 24'd100000, 1'b1, 1'b0);
    send_hit(24'd65536, 24'd0, 24'd65536, 1'b0, 1'b0);
    send_hit(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 1'b1, 1'b0);
    send_hit(24'h800000, 24'h800000, 24'h800000, 1'b0, 1'b0);
    send_hit(24'h800000, 24'h7FFFFF, 24'h000001, 1'b1, 1'b1);

    // k below zero: on-axis tie and negative discriminant
    load_track(24'd0, 24'd0, 24'd0, 18'd0, 18'd0, 18'd32768, 17'd36193);
    send_hit(24'd0, 24'd0, 24'd65536, 1'b0, 1'b0);
    send_hit(24'd65536, 24'd0, 24'd0, 1'b1, 1'b0);
    send_hit(24'hFF0000, 24'd0, 24'h800000, 1'b0, 1'b1);

    // zero direction: alpha zero over a long event
    load_track(24'd0, 24'd0, 24'd0, 18'd0, 18'd0, 18'd0, 17'd36193);
    for (int i = 0; i < 200; i++)
      send_hit(rand_pos(), rand_pos(), rand_pos(), i[0], i == 199, 1);

    // k exactly zero
    load_track(24'd0, 24'd0, 24'd0, 18'd0, 18'd0, 18'd65536, 17'd65536);
    send_hit(24'd65536, 24'd65536, 24'd0, 1'b0, 1'b1);

    // zero cos_sq: tie
    load_track(24'd0, 24'd0, 24'd0, 18'd65536, 18'd0, 18'd0, 17'd0);
    send_hit(24'd65536, 24'd131072, 24'd5, 1'b1, 1'b1);

    // register extremes
    load_track(24'h7FFFFF, 24'h800000, 24'h7FFFFF,
               18'h20000, 18'h1FFFF, 18'h20000, 17'h1FFFF);
    send_hit(24'h800000, 24'h7FFFFF, 24'h800000, 1'b0, 1'b0);
    send_hit(24'h7FFFFF, 24'h800000, 24'h7FFFFF, 1'b1, 1'b0);
    send_hit(24'd0, 24'd0, 24'd0, 1'b0, 1'b1);
    load_track(24'h800000, 24'h7FFFFF, 24'h800000,
               18'h1FFFF, 18'h20000, 18'h1FFFF, 17'd1);
    send_hit(24'h7FFFFF, 24'h800000, 24'h7FFFFF, 1'b0, 1'b0);
    send_hit(24'h123456, 24'hABCDEF, 24'h0F0F0F, 1'b1, 1'b1);

    // randomised setups and events
    for (int ph = 0; ph < 4; ph++) begin
      r = $urandom();
      load_track(rand_pos(), rand_pos(), rand_pos(),
                 18'($urandom()), 18'($urandom()), 18'($urandom()),
                 (r[3:0] == 0) ? 17'($urandom()) : 17'($urandom_range(20000, 60000)));
      burst = $urandom_range(0, 1);
      for (int i = 0; i < 45; i++)
        send_hit(rand_pos(), rand_pos(), rand_pos(), 1'($urandom()),
                 ($urandom_range(0, 9) == 0) || i == 44, burst && i < 20);
    end

    hit_if.valid <= 1'b0;
    @(negedge clk_i);
    wait (pending == 0);
    repeat (400) @(negedge clk_i);
    if (fail_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
